>>> rtl/zero_spread_cross_window_top_defines.svh
// assertion macros for the zero spread block
`ifndef ZERO_SPREAD_CROSS_WINDOW_TOP_DEFINES_SVH
`define ZERO_SPREAD_CROSS_WINDOW_TOP_DEFINES_SVH

// property must hold at every clock edge out of reset
`define ZSCW_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("zscw assertion failed");

// condition must never be seen at a clock edge out of reset
`define ZSCW_NEVER(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("zscw forbidden condition seen");

`endif

>>> rtl/zscw_pkg.sv
// shared constants and types of the zero spread block
package zscw_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int VAL_W      = 32;
    localparam int WCFG_W     = 11;
    localparam int HCFG_W     = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = CFG_IDX_W'(1);

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

    // one classified input cell with its line buffer reads
    typedef struct packed {
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic signed [VAL_W-1:0] prior_mid;
        logic                    prior_right_zero;
        logic                    older_zero;
        logic                    has_up;
        logic                    last_row;
        logic                    col_ge1;
        logic                    col_ge2;
        logic                    has_last;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

>>> rtl/zscw_intf.sv
// stream and configuration channel interfaces
interface zscw_in_if import zscw_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

interface zscw_out_if import zscw_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    frame_last;

    modport source (output valid, output out_row, output out_col, output out_value,
                    output frame_last, input ready);
    modport sink   (input valid, input out_row, input out_col, input out_value,
                    input frame_last, output ready);
endinterface

interface zscw_cfg_if import zscw_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/zscw_linebuf.sv
// two row banks, written on alternate rows, each read at col and col+1
module zscw_linebuf import zscw_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic                    i_wr_bank,
    input  logic [COL_W-1:0]        i_col,
    input  logic [COL_W-1:0]        i_col_next,
    input  logic signed [VAL_W-1:0] i_wdata,
    output logic signed [VAL_W-1:0] o_prior_mid,
    output logic signed [VAL_W-1:0] o_prior_right,
    output logic signed [VAL_W-1:0] o_older
);

    logic signed [VAL_W-1:0] mem_a [MAX_WIDTH];
    logic signed [VAL_W-1:0] mem_b [MAX_WIDTH];

    logic signed [VAL_W-1:0] r_a_mid;
    logic signed [VAL_W-1:0] r_a_right;
    logic signed [VAL_W-1:0] r_b_mid;
    logic signed [VAL_W-1:0] r_b_right;
    logic                    r_bank;

    // read-first: the write bank's mid read returns the row two rows up
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_mid   <= mem_a[i_col];
            r_a_right <= mem_a[i_col_next];
            if (!i_wr_bank) begin
                mem_a[i_col] <= i_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_mid   <= mem_b[i_col];
            r_b_right <= mem_b[i_col_next];
            if (i_wr_bank) begin
                mem_b[i_col] <= i_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_bank <= i_wr_bank;
        end
    end

    assign o_prior_mid   = r_bank ? r_a_mid   : r_b_mid;
    assign o_prior_right = r_bank ? r_a_right : r_b_right;
    assign o_older       = r_bank ? r_b_mid   : r_a_mid;

endmodule

>>> rtl/zscw_front.sv
// front end: config registers, raster counters, line buffer access, classification
module zscw_front import zscw_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    zscw_in_if.sink         i_cell,
    zscw_cfg_if.sink        i_cfg,
    input  t_q_status       i_q_status,
    output logic            o_push,
    output t_item           o_item
);

    typedef struct packed {
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic                    has_up;
        logic                    last_row;
        logic                    col_ge1;
        logic                    col_ge2;
        logic                    row_ge2;
        logic                    right_in;
        logic                    has_last;
    } t_s1_meta;

    logic [WCFG_W-1:0] r_grid_width;
    logic [HCFG_W-1:0] r_grid_height;
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [ROW_W-1:0]  n_row;
    logic [COL_W-1:0]  n_col;
    logic              r_s1_valid;
    t_s1_meta          r_s1;

    logic [WCFG_W-1:0] w_eff;
    logic [HCFG_W-1:0] h_eff;
    logic [COL_W-1:0]  col_cur;
    logic [ROW_W-1:0]  row_cur;
    logic              col_is_last;
    logic              row_is_last;
    logic              accept;
    logic              cfg_hit;
    logic signed [VAL_W-1:0] prior_mid;
    logic signed [VAL_W-1:0] prior_right;
    logic signed [VAL_W-1:0] older;

    // out-of-range sizes saturate
    assign w_eff = (r_grid_width == '0) ? WCFG_W'(1)
                 : (r_grid_width > WCFG_W'(MAX_WIDTH)) ? WCFG_W'(MAX_WIDTH) : r_grid_width;
    assign h_eff = (r_grid_height == '0) ? HCFG_W'(1)
                 : (r_grid_height > HCFG_W'(MAX_HEIGHT)) ? HCFG_W'(MAX_HEIGHT) : r_grid_height;

    assign col_cur = (WCFG_W'(r_col) >= w_eff) ? '0 : r_col;
    assign row_cur = (HCFG_W'(r_row) >= h_eff) ? '0 : r_row;
    assign col_is_last = (WCFG_W'(col_cur) == w_eff - WCFG_W'(1));
    assign row_is_last = (HCFG_W'(row_cur) == h_eff - HCFG_W'(1));

    assign o_push       = r_s1_valid && !i_q_status.full;
    assign i_cell.ready = !r_s1_valid || o_push;
    assign accept       = i_cell.valid && i_cell.ready;
    assign i_cfg.ready  = 1'b1;
    assign cfg_hit      = i_cfg.valid && i_cfg.ready
                          && (i_cfg.index == CFG_GRID_WIDTH || i_cfg.index == CFG_GRID_HEIGHT);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (cfg_hit) begin
            n_col = '0;
            n_row = '0;
        end else if (accept) begin
            if (col_is_last) begin
                n_col = '0;
                n_row = row_is_last ? '0 : row_cur + ROW_W'(1);
            end else begin
                n_col = col_cur + COL_W'(1);
                n_row = row_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width  <= WCFG_W'(MAX_WIDTH);
            r_grid_height <= HCFG_W'(1024);
            r_row         <= '0;
            r_col         <= '0;
            r_s1_valid    <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_GRID_WIDTH:  r_grid_width  <= i_cfg.data[WCFG_W-1:0];
                    CFG_GRID_HEIGHT: r_grid_height <= i_cfg.data[HCFG_W-1:0];
                    default: ;
                endcase
            end
            r_row <= n_row;
            r_col <= n_col;
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.row      <= row_cur;
            r_s1.col      <= col_cur;
            r_s1.value    <= i_cell.cell_value;
            r_s1.has_up   <= (row_cur != '0);
            r_s1.last_row <= row_is_last;
            r_s1.col_ge1  <= (col_cur != '0);
            r_s1.col_ge2  <= (col_cur >= COL_W'(2));
            r_s1.row_ge2  <= (row_cur >= ROW_W'(2));
            r_s1.right_in <= (WCFG_W'(col_cur) + WCFG_W'(1) < w_eff);
            r_s1.has_last <= row_is_last && col_is_last;
        end
    end

    // current row goes to the bank picked by row parity
    zscw_linebuf u_linebuf (
        .i_clk         (i_clk),
        .i_en          (accept),
        .i_wr_bank     (row_cur[0]),
        .i_col         (col_cur),
        .i_col_next    (col_cur + COL_W'(1)),
        .i_wdata       (i_cell.cell_value),
        .o_prior_mid   (prior_mid),
        .o_prior_right (prior_right),
        .o_older       (older)
    );

    always_comb begin
        o_item.row              = r_s1.row;
        o_item.col              = r_s1.col;
        o_item.value            = r_s1.value;
        o_item.prior_mid        = prior_mid;
        o_item.prior_right_zero = r_s1.right_in && (prior_right == '0);
        o_item.older_zero       = r_s1.row_ge2 && (older == '0);
        o_item.has_up           = r_s1.has_up;
        o_item.last_row         = r_s1.last_row;
        o_item.col_ge1          = r_s1.col_ge1;
        o_item.col_ge2          = r_s1.col_ge2;
        o_item.has_last         = r_s1.has_last;
    end

endmodule

>>> rtl/zscw_queue.sv
// short fifo of classified cells between front and back
module zscw_queue import zscw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_item,
    output t_q_status o_status
);

    t_item            r_mem [QUEUE_DEPTH];
    logic [Q_PTR_W:0] r_wr_ptr;
    logic [Q_PTR_W:0] r_rd_ptr;

    assign o_status.empty = (r_wr_ptr == r_rd_ptr);
    assign o_status.full  = (r_wr_ptr[Q_PTR_W] != r_rd_ptr[Q_PTR_W])
                            && (r_wr_ptr[Q_PTR_W-1:0] == r_rd_ptr[Q_PTR_W-1:0]);
    assign o_item = r_mem[r_rd_ptr[Q_PTR_W-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + (Q_PTR_W+1)'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + (Q_PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr[Q_PTR_W-1:0]] <= i_item;
        end
    end

endmodule

>>> rtl/zscw_back.sv
// back end: zero test and result sequencing, up to three results per cell
module zscw_back import zscw_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_item     i_item,
    input  t_q_status i_q_status,
    output logic      o_pop,
    zscw_out_if.source o_result
);

    localparam int RES_UP   = 0;
    localparam int RES_LEFT = 1;
    localparam int RES_LAST = 2;

    logic [2:0]              r_done;
    logic signed [VAL_W-1:0] r_prior_left;
    logic signed [VAL_W-1:0] r_cur1;
    logic signed [VAL_W-1:0] r_cur2;
    logic                    r_out_valid;
    logic [ROW_W-1:0]        r_out_row;
    logic [COL_W-1:0]        r_out_col;
    logic signed [VAL_W-1:0] r_out_value;
    logic                    r_out_last;

    logic [2:0]              need;
    logic [2:0]              pending;
    logic [2:0]              sel;
    logic                    head_valid;
    logic                    out_free;
    logic                    emit;
    logic                    v_zero;
    logic                    up_zero;
    logic                    left_zero;
    logic                    last_zero;
    logic [ROW_W-1:0]        res_row;
    logic [COL_W-1:0]        res_col;
    logic signed [VAL_W-1:0] res_value;

    assign head_valid = !i_q_status.empty;
    assign out_free   = !r_out_valid || o_result.ready;

    always_comb begin
        need           = '0;
        need[RES_UP]   = i_item.has_up;
        need[RES_LEFT] = i_item.last_row && i_item.col_ge1;
        need[RES_LAST] = i_item.has_last;
    end

    assign pending = need & ~r_done;
    // lowest pending result goes first
    assign sel   = pending & (~pending + 3'd1);
    assign emit  = head_valid && (pending != '0) && out_free;
    assign o_pop = head_valid && ((pending == '0) || (emit && (pending & ~sel) == '0));

    assign v_zero    = (i_item.value == '0);
    assign up_zero   = (i_item.prior_mid == '0) || v_zero || i_item.older_zero
                       || (i_item.col_ge1 && r_prior_left == '0) || i_item.prior_right_zero;
    assign left_zero = (r_cur1 == '0) || v_zero
                       || (i_item.has_up && r_prior_left == '0)
                       || (i_item.col_ge2 && r_cur2 == '0);
    assign last_zero = v_zero || (i_item.has_up && i_item.prior_mid == '0)
                       || (i_item.col_ge1 && r_cur1 == '0);

    always_comb begin
        res_row   = i_item.row;
        res_col   = i_item.col;
        res_value = last_zero ? '0 : i_item.value;
        if (sel[RES_UP]) begin
            res_row   = i_item.row - ROW_W'(1);
            res_value = up_zero ? '0 : i_item.prior_mid;
        end else if (sel[RES_LEFT]) begin
            res_col   = i_item.col - COL_W'(1);
            res_value = left_zero ? '0 : r_cur1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_done <= '0;
            end else if (emit) begin
                r_done <= r_done | sel;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_row   <= res_row;
            r_out_col   <= res_col;
            r_out_value <= res_value;
            r_out_last  <= sel[RES_LAST];
        end
        // window of the previous cell in the row
        if (o_pop) begin
            r_prior_left <= i_item.prior_mid;
            r_cur1       <= i_item.value;
            r_cur2       <= r_cur1;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.out_row    = r_out_row;
    assign o_result.out_col    = r_out_col;
    assign o_result.out_value  = r_out_value;
    assign o_result.frame_last = r_out_last;

endmodule

>>> rtl/zero_spread_cross_window_top.sv
// top level of the four-neighbour zero spread block
// throughput: one cell per cycle while the queue is not full; on the last row of a frame the
//   output port limits it (up to three results per cell); the 4-entry queue absorbs bursts
// reset: synchronous active low, size registers return to 1024 x 1024 and the
//   raster position to row 0 col 0; line buffer contents are not cleared
`include "zero_spread_cross_window_top_defines.svh"

module zero_spread_cross_window_top import zscw_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    zscw_in_if.sink    i_cell,
    zscw_cfg_if.sink   i_cfg,
    zscw_out_if.source o_result
);

    t_item     push_item;
    t_item     head_item;
    t_q_status q_status;
    logic      q_push;
    logic      q_pop;

    zscw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cell     (i_cell),
        .i_cfg      (i_cfg),
        .i_q_status (q_status),
        .o_push     (q_push),
        .o_item     (push_item)
    );

    zscw_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_item   (push_item),
        .i_pop    (q_pop),
        .o_item   (head_item),
        .o_status (q_status)
    );

    zscw_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (head_item),
        .i_q_status (q_status),
        .o_pop      (q_pop),
        .o_result   (o_result)
    );

    `ZSCW_NEVER(a_push_when_full, q_push && q_status.full)
    `ZSCW_NEVER(a_pop_when_empty, q_pop && q_status.empty)
    `ZSCW_ASSERT(a_push_fills_queue, q_push && !q_pop |=> !q_status.empty)

endmodule

>>> verif/tb_zero_spread_cross_window_top.sv
// self-checking testbench of the four-neighbour zero spread block
module tb_zero_spread_cross_window_top;
    import zscw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;
    localparam int SAT_CELLS    = 60;
    localparam int RANDOM_CELLS = 90;

    // indexes past the register list, the block ignores them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = CFG_IDX_W'(3);

    typedef struct packed {
        logic [ROW_W-1:0]        row;
        logic [COL_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } t_spread_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    zscw_in_if  grid_in ();
    zscw_cfg_if grid_cfg ();
    zscw_out_if grid_out ();

    zero_spread_cross_window_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cell   (grid_in),
        .i_cfg    (grid_cfg),
        .o_result (grid_out)
    );

    always #5 i_clk = ~i_clk;

    // predictor state
    logic [VAL_W-1:0]  prior_vals [MAX_WIDTH];
    logic [VAL_W-1:0]  curr_vals  [MAX_WIDTH];
    logic              older_zero [MAX_WIDTH];
    logic [WCFG_W-1:0] width_reg;
    logic [HCFG_W-1:0] height_reg;
    int unsigned       row_pos;
    int unsigned       col_pos;

    t_spread_result pending_results[$];

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int hold_request  = 0;
    int hold_left     = 0;
    int fail_count    = 0;
    int cells_sent    = 0;
    int results_seen  = 0;
    int reg_writes    = 0;
    int cycle_count   = 0;

    function automatic int unsigned eff_width();
        int unsigned w;
        w = width_reg;
        if (w < 1) w = 1;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = height_reg;
        if (h < 1) h = 1;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        return h;
    endfunction

    function automatic void push_result(input int unsigned r, input int unsigned c,
                                        input logic [VAL_W-1:0] v, input logic last);
        t_spread_result item;
        item.row   = r[ROW_W-1:0];
        item.col   = c[COL_W-1:0];
        item.value = v;
        item.last  = last;
        pending_results.push_back(item);
    endfunction

    function automatic void predict_spread(input logic [VAL_W-1:0] v);
        int unsigned      w;
        int unsigned      h;
        int unsigned      r;
        int unsigned      c;
        logic             z;
        logic [VAL_W-1:0] mid;
        w = eff_width();
        h = eff_height();
        r = row_pos;
        c = col_pos;
        if (c >= w) c = 0;
        if (r >= h) r = 0;

        // cell one row up, its lower neighbour is arriving now
        if (r >= 1) begin
            mid = prior_vals[c];
            z = (mid == '0) || (v == '0)
                || ((r >= 2) ? older_zero[c] : 1'b0)
                || ((c > 0) ? (prior_vals[c-1] == '0) : 1'b0)
                || ((c + 1 < w) ? (prior_vals[c+1] == '0) : 1'b0);
            push_result(r - 1, c, z ? '0 : mid, 1'b0);
        end

        curr_vals[c] = v;

        if (r == h - 1) begin
            // left neighbour on the last row is now complete
            if (c >= 1) begin
                mid = curr_vals[c-1];
                z = (mid == '0) || (v == '0)
                    || ((r >= 1) ? (prior_vals[c-1] == '0) : 1'b0)
                    || ((c >= 2) ? (curr_vals[c-2] == '0) : 1'b0);
                push_result(r, c - 1, z ? '0 : mid, 1'b0);
            end
            if (c == w - 1) begin
                z = (v == '0)
                    || ((r >= 1) ? (prior_vals[c] == '0) : 1'b0)
                    || ((c >= 1) ? (curr_vals[c-1] == '0) : 1'b0);
                push_result(r, c, z ? '0 : v, 1'b1);
            end
        end

        c++;
        if (c >= w) begin
            c = 0;
            for (int unsigned i = 0; i < w; i++) begin
                older_zero[i] = (prior_vals[i] == '0);
                prior_vals[i] = curr_vals[i];
            end
            r++;
            if (r >= h) r = 0;
        end
        row_pos = r;
        col_pos = c;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_GRID_WIDTH) begin
            width_reg = data[WCFG_W-1:0];
        end else if (idx == CFG_GRID_HEIGHT) begin
            height_reg = data[HCFG_W-1:0];
        end else begin
            return;
        end
        row_pos = 0;
        col_pos = 0;
    endfunction

    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(0, 15))
            0, 1:    return '0;
            2:       return {1'b0, {(VAL_W-1){1'b1}}};
            3:       return {1'b1, {(VAL_W-1){1'b0}}};
            4:       return '1;
            5:       return VAL_W'(1);
            default: return $urandom();
        endcase
    endfunction

    // one cell transfer; returns at the falling edge after acceptance, valid left high
    task automatic send_cell(input logic signed [VAL_W-1:0] v);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            grid_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        grid_in.valid      <= 1'b1;
        grid_in.cell_value <= v;
        @(posedge i_clk);
        while (!grid_in.ready) @(posedge i_clk);
        predict_spread(v);
        cells_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        grid_cfg.valid <= 1'b1;
        grid_cfg.index <= idx;
        grid_cfg.data  <= data;
        @(posedge i_clk);
        while (!grid_cfg.ready) @(posedge i_clk);
        apply_reg_write(idx, data);
        reg_writes++;
        @(negedge i_clk);
        grid_cfg.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        grid_in.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic send_random_cells(input int count);
        repeat (count) send_cell(random_value());
    endtask

    task automatic test_reset_size();
        // default 1024 x 1024, first row gives nothing
        send_cell(32'sd17);
        wait_idle();
    endtask

    task automatic test_field_extremes();
        write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(3));
        write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(3));
        send_cell(32'sh7FFF_FFFF);
        send_cell(32'sd5);
        send_cell(32'sh8000_0000);
        send_cell(-32'sd3);
        send_cell(32'sd0);
        send_cell(32'sd9);
        send_cell(-32'sd1);
        send_cell(32'sd2);
        send_cell(32'sd1);
        // frame wrapped, this starts row 0 again
        send_cell(32'sd4);
        wait_idle();
    endtask

    task automatic test_thin_grids();
        write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(4));
        write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(1));
        send_cell(32'sd11);
        send_cell(32'sd0);
        send_cell(32'sd13);
        send_cell(32'sd14);
        wait_idle();
        write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(1));
        write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(3));
        send_cell(32'sd21);
        send_cell(32'sd22);
        send_cell(32'sd0);
        wait_idle();
        // zero sizes act as one
        write_reg(CFG_GRID_WIDTH, '0);
        write_reg(CFG_GRID_HEIGHT, '0);
        send_cell(32'sd31);
        send_cell(32'sd0);
        wait_idle();
    endtask

    task automatic test_spare_index();
        write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(2));
        write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(2));
        send_cell(32'sd41);
        wait_idle();
        // must not restart the frame
        write_reg(CFG_SPARE_LO, CFG_DATA_W'($urandom()));
        write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom()));
        send_cell(32'sd42);
        send_cell(32'sd43);
        send_cell(32'sd44);
        wait_idle();
    endtask

    task automatic test_restart();
        send_cell(32'sd51);
        send_cell(32'sd52);
        wait_idle();
        write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(2));
        send_cell(32'sd53);
        send_cell(32'sd54);
        send_cell(32'sd55);
        send_cell(32'sd56);
        wait_idle();
    endtask

    task automatic test_pressure();
        int saved_src;
        saved_src    = src_idle_pct;
        src_idle_pct = 0;
        write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(6));
        write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(10));
        hold_request = HOLD_CYCLES;
        send_random_cells(60);
        wait_idle();
        src_idle_pct = saved_src;
    endtask

    task automatic test_width_saturation();
        // all data bits high, width saturates to the line buffer size
        // single row, so every cell past the first gives a result
        write_reg(CFG_GRID_WIDTH, '1);
        write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(1));
        send_random_cells(SAT_CELLS);
        wait_idle();
    endtask

    task automatic test_height_saturation();
        // single column, every row past the first gives a result
        write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(1));
        write_reg(CFG_GRID_HEIGHT, '1);
        send_random_cells(SAT_CELLS);
        wait_idle();
    endtask

    task automatic test_random_frames(input int budget);
        int sent;
        int w_data;
        int h_data;
        int n;
        sent = 0;
        while (sent < budget) begin
            w_data = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            h_data = $urandom_range(1, 6);
            if ($urandom_range(0, 15) == 0) w_data = 0;
            if ($urandom_range(0, 15) == 0) h_data = 0;
            write_reg(CFG_GRID_WIDTH, CFG_DATA_W'(w_data));
            if ($urandom_range(0, 3) != 0) write_reg(CFG_GRID_HEIGHT, CFG_DATA_W'(h_data));
            n = eff_width() * eff_height();
            case ($urandom_range(0, 7))
                0:       n = $urandom_range(1, n);   // broken frame, cut by the next write
                1:       n = 2 * n;
                default: ;
            endcase
            if (n > budget - sent) n = budget - sent;
            send_random_cells(n);
            sent += n;
            wait_idle();
        end
    endtask

    // receiver side: random ready, with a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            grid_out.ready <= 1'b0;
        end else begin
            grid_out.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_spread_result exp_item;
        if (i_rst_n && grid_out.valid && grid_out.ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                $error("unexpected result row %0d col %0d value %0d",
                       grid_out.out_row, grid_out.out_col, grid_out.out_value);
                fail_count++;
            end else begin
                exp_item = pending_results.pop_front();
                if (grid_out.out_row !== exp_item.row) begin
                    $error("out_row expected %0d actual %0d", exp_item.row, grid_out.out_row);
                    fail_count++;
                end
                if (grid_out.out_col !== exp_item.col) begin
                    $error("out_col expected %0d actual %0d", exp_item.col, grid_out.out_col);
                    fail_count++;
                end
                if (grid_out.out_value !== exp_item.value) begin
                    $error("out_value expected %0d actual %0d",
                           exp_item.value, grid_out.out_value);
                    fail_count++;
                end
                if (grid_out.frame_last !== exp_item.last) begin
                    $error("frame_last expected %0d actual %0d",
                           exp_item.last, grid_out.frame_last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_zero_spread_cross_window_top NOT OK");
            $finish;
        end
    end

    initial begin
        i_rst_n             = 1'b0;
        grid_in.valid       = 1'b0;
        grid_in.cell_value  = '0;
        grid_cfg.valid      = 1'b0;
        grid_cfg.index      = '0;
        grid_cfg.data       = '0;
        grid_out.ready      = 1'b0;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            prior_vals[i] = '0;
            curr_vals[i]  = '0;
            older_zero[i] = 1'b0;
        end
        width_reg  = WCFG_W'(1024);
        height_reg = HCFG_W'(1024);
        row_pos    = 0;
        col_pos    = 0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        src_idle_pct  = 20;
        sink_idle_pct = 67;
        test_reset_size();
        test_field_extremes();
        test_thin_grids();
        test_spare_index();
        test_restart();
        test_random_frames(RANDOM_CELLS);

        src_idle_pct  = 67;
        sink_idle_pct = 20;
        test_pressure();
        test_random_frames(RANDOM_CELLS);

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        test_width_saturation();
        test_height_saturation();
        test_random_frames(RANDOM_CELLS);

        wait_idle();
        $display("sent %0d cells over %0d register writes, checked %0d results",
                 cells_sent, reg_writes, results_seen);
        $display("grids from 1x1 up to saturated width and height, with stalls on both sides");
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("tb_zero_spread_cross_window_top OK");
        end else begin
            $display("tb_zero_spread_cross_window_top NOT OK");
        end
        $finish;
    end

endmodule

>>> zero_spread_cross_window_top.f
+incdir+rtl
rtl/zscw_pkg.sv
rtl/zscw_intf.sv
rtl/zscw_linebuf.sv
rtl/zscw_front.sv
rtl/zscw_queue.sv
rtl/zscw_back.sv
rtl/zero_spread_cross_window_top.sv
verif/tb_zero_spread_cross_window_top.sv
